### src/tftpsc_pkg.sv
// Shared types, codes and helpers for the TFTP session controller.
package tftpsc_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam logic [9:0] LEN_LIMIT = (BLOCK_BYTES > 1023) ? 10'd1023 : 10'(BLOCK_BYTES);
   localparam logic [10:0] BLOCK_LEN = 11'(BLOCK_BYTES);
   localparam logic [3:0] MAX_RETRIES_RESET = 4'd10;

   localparam logic [1:0] CMD_PACKET = 2'd0;
   localparam logic [1:0] CMD_TX_EXPIRED = 2'd1;
   localparam logic [1:0] CMD_RX_EXPIRED = 2'd2;

   localparam logic [15:0] OP_RRQ = 16'd1;
   localparam logic [15:0] OP_WRQ = 16'd2;
   localparam logic [15:0] OP_DATA = 16'd3;
   localparam logic [15:0] OP_ACK = 16'd4;
   localparam logic [15:0] OP_ERROR = 16'd5;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_ACK = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] TIMER_LEAVE = 2'd0;
   localparam logic [1:0] TIMER_RESTART = 2'd1;
   localparam logic [1:0] TIMER_STOP = 2'd2;

   localparam logic [2:0] FILE_NONE = 3'd0;
   localparam logic [2:0] FILE_OPEN_READ = 3'd1;
   localparam logic [2:0] FILE_OPEN_WRITE = 3'd2;
   localparam logic [2:0] FILE_READ_NEXT = 3'd3;
   localparam logic [2:0] FILE_WRITE = 3'd4;
   localparam logic [2:0] FILE_WRITE_CLOSE = 3'd5;
   localparam logic [2:0] FILE_CLOSE = 3'd6;

   localparam logic [2:0] MSG_BUSY = 3'd0;
   localparam logic [2:0] MSG_RRQ_UNEXPECTED = 3'd1;
   localparam logic [2:0] MSG_WRQ_UNEXPECTED = 3'd2;
   localparam logic [2:0] MSG_NOT_FOUND = 3'd3;
   localparam logic [2:0] MSG_CANNOT_WRITE = 3'd4;
   localparam logic [2:0] MSG_NOT_OPEN = 3'd5;

   localparam logic [15:0] ERR_CODE_BUSY = 16'd0;
   localparam logic [15:0] ERR_CODE_ILLEGAL = 16'd1;
   localparam logic [15:0] ERR_CODE_NOT_FOUND = 16'd2;
   localparam logic [15:0] ERR_CODE_NOT_OPEN = 16'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic        dest_is_broadcast;
      logic [15:0] opcode;
      logic [15:0] block_id;
      logic [9:0]  payload_len;
      logic        mode_octet;
      logic        open_ok;
      logic [9:0]  read_bytes;
   } item_type;

   typedef struct packed {
      logic [31:0] client_addr;
      logic [15:0] client_port;
      logic        file_is_open;
      logic        binary_flag;
      logic        final_block;
      logic [15:0] block_num;
      logic [15:0] prev_block;
      logic [3:0]  retry_count;
      logic [9:0]  last_len;
   } session_type;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic [15:0] block_or_code;
      logic [2:0]  error_message;
      logic [9:0]  data_len;
      logic [2:0]  file_action;
      logic        open_binary;
      logic [1:0]  tx_timer_cmd;
      logic [1:0]  rx_timer_cmd;
      logic        session_active;
   } result_type;

   function automatic logic [9:0] sat_len(input logic [9:0] v);
      sat_len = (v > LEN_LIMIT) ? LEN_LIMIT : v;
   endfunction

endpackage

### src/tftpsc_in_stage.sv
// Input register stage holding one accepted event word.
module tftpsc_in_stage import tftpsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_stall,
   input  logic     advance,
   output logic     out_valid,
   output item_type out_item
);

   logic     vld_ff;
   logic     vld_in;
   item_type item_ff;
   logic     load;

   assign in_stall = vld_ff & ~advance;
   assign load = in_valid & ~in_stall;
   assign vld_in = load | (vld_ff & ~advance);
   assign out_valid = vld_ff;
   assign out_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

endmodule

### src/tftpsc_decide.sv
// Event decision logic: next session state and result word for one event.
module tftpsc_decide import tftpsc_pkg::*; (
   input  item_type    item,
   input  session_type cur,
   input  logic [3:0]  max_retries,
   output session_type nxt,
   output result_type  res
);

   logic [9:0]  plen;
   logic [9:0]  rlen;
   logic [16:0] diff;
   logic        no_file;
   logic [15:0] blk_inc;

   assign plen = sat_len(item.payload_len);
   assign rlen = sat_len(item.read_bytes);
   assign diff = {1'b0, item.block_id} - {1'b0, cur.prev_block};
   assign no_file = ~cur.file_is_open | (cur.client_addr == 32'd0);
   assign blk_inc = cur.block_num + 16'd1;

   always_comb begin
      nxt = cur;
      res = '0;
      case (item.command)
         CMD_TX_EXPIRED: begin
            if (cur.retry_count >= max_retries) begin
               res.tx_timer_cmd = TIMER_STOP;
               nxt.binary_flag = 1'b0;
               if (cur.file_is_open) begin
                  res.file_action = FILE_CLOSE;
                  nxt.file_is_open = 1'b0;
               end
               nxt.client_addr = '0;
               nxt.retry_count = '0;
            end else begin
               nxt.retry_count = cur.retry_count + 4'd1;
               if (no_file) begin
                  res.tx_timer_cmd = TIMER_STOP;
               end else begin
                  res.send_kind = KIND_DATA;
                  res.dest_ip = cur.client_addr;
                  res.dest_port = cur.client_port;
                  res.block_or_code = cur.block_num;
                  res.data_len = cur.last_len;
                  res.tx_timer_cmd = TIMER_RESTART;
               end
            end
         end
         CMD_RX_EXPIRED: begin
            res.rx_timer_cmd = TIMER_STOP;
            nxt.binary_flag = 1'b0;
            if (cur.file_is_open) begin
               res.file_action = FILE_CLOSE;
               nxt.file_is_open = 1'b0;
            end
            nxt.client_addr = '0;
         end
         CMD_PACKET: begin
            if (!item.dest_is_broadcast) begin
               if ((cur.client_addr != 32'd0) && (item.src_ip != cur.client_addr)) begin
                  res.send_kind = KIND_ERROR;
                  res.dest_ip = item.src_ip;
                  res.dest_port = item.src_port;
                  res.block_or_code = ERR_CODE_BUSY;
                  res.error_message = MSG_BUSY;
               end else begin
                  res.rx_timer_cmd = TIMER_RESTART;
                  case (item.opcode)
                     OP_RRQ, OP_WRQ: begin
                        res.dest_ip = item.src_ip;
                        res.dest_port = item.src_port;
                        if (cur.client_addr != 32'd0) begin
                           res.send_kind = KIND_ERROR;
                           res.block_or_code = ERR_CODE_ILLEGAL;
                           if (item.opcode == OP_RRQ) begin
                              res.tx_timer_cmd = TIMER_STOP;
                              res.error_message = MSG_RRQ_UNEXPECTED;
                           end else begin
                              res.error_message = MSG_WRQ_UNEXPECTED;
                           end
                           nxt.binary_flag = 1'b0;
                           if (cur.file_is_open) begin
                              res.file_action = FILE_CLOSE;
                              nxt.file_is_open = 1'b0;
                           end
                           nxt.client_addr = '0;
                        end else begin
                           nxt.client_addr = item.src_ip;
                           nxt.client_port = item.src_port;
                           nxt.binary_flag = item.mode_octet;
                           res.open_binary = item.mode_octet;
                           res.file_action = (item.opcode == OP_RRQ) ?
                                             FILE_OPEN_READ : FILE_OPEN_WRITE;
                           if (!item.open_ok) begin
                              res.send_kind = KIND_ERROR;
                              res.block_or_code = ERR_CODE_NOT_FOUND;
                              res.error_message = (item.opcode == OP_RRQ) ?
                                                  MSG_NOT_FOUND : MSG_CANNOT_WRITE;
                              nxt.client_addr = '0;
                           end else if (item.opcode == OP_RRQ) begin
                              nxt.file_is_open = 1'b1;
                              nxt.last_len = rlen;
                              nxt.final_block = ({1'b0, rlen} != BLOCK_LEN);
                              nxt.block_num = 16'd1;
                              nxt.retry_count = '0;
                              res.send_kind = KIND_DATA;
                              res.block_or_code = 16'd1;
                              res.data_len = rlen;
                              res.tx_timer_cmd = TIMER_RESTART;
                           end else begin
                              nxt.file_is_open = 1'b1;
                              nxt.block_num = '0;
                              nxt.final_block = 1'b0;
                              nxt.prev_block = '0;
                              res.send_kind = KIND_ACK;
                              res.block_or_code = '0;
                           end
                        end
                     end
                     OP_DATA: begin
                        nxt.block_num = item.block_id;
                        res.dest_ip = item.src_ip;
                        res.dest_port = item.src_port;
                        if ((cur.prev_block != 16'd0) && (cur.prev_block == item.block_id)) begin
                           res.send_kind = KIND_ACK;
                           res.block_or_code = item.block_id;
                        end else if (!diff[16] && (diff > 17'd1)) begin
                           res.send_kind = KIND_ACK;
                           res.block_or_code = cur.prev_block;
                        end else begin
                           nxt.prev_block = item.block_id;
                           if (no_file) begin
                              res.send_kind = KIND_ERROR;
                              res.block_or_code = ERR_CODE_NOT_OPEN;
                              res.error_message = MSG_NOT_OPEN;
                           end else begin
                              nxt.last_len = plen;
                              if ({1'b0, plen} != BLOCK_LEN) begin
                                 res.file_action = FILE_WRITE_CLOSE;
                                 nxt.file_is_open = 1'b0;
                                 nxt.client_addr = '0;
                              end else begin
                                 res.file_action = FILE_WRITE;
                              end
                              res.send_kind = KIND_ACK;
                              res.block_or_code = item.block_id;
                           end
                        end
                     end
                     OP_ACK: begin
                        nxt.retry_count = '0;
                        if (no_file) begin
                           res.send_kind = KIND_ERROR;
                           res.dest_ip = item.src_ip;
                           res.dest_port = item.src_port;
                           res.block_or_code = ERR_CODE_NOT_OPEN;
                           res.error_message = MSG_NOT_OPEN;
                           res.tx_timer_cmd = TIMER_STOP;
                        end else if (cur.final_block) begin
                           res.tx_timer_cmd = TIMER_STOP;
                           res.file_action = FILE_CLOSE;
                           nxt.file_is_open = 1'b0;
                           nxt.client_addr = '0;
                        end else begin
                           nxt.block_num = blk_inc;
                           nxt.last_len = rlen;
                           nxt.final_block = ({1'b0, rlen} != BLOCK_LEN);
                           res.file_action = FILE_READ_NEXT;
                           res.send_kind = KIND_DATA;
                           res.dest_ip = item.src_ip;
                           res.dest_port = item.src_port;
                           res.block_or_code = blk_inc;
                           res.data_len = rlen;
                           res.tx_timer_cmd = TIMER_RESTART;
                        end
                     end
                     OP_ERROR: begin
                        res.tx_timer_cmd = TIMER_STOP;
                        nxt.binary_flag = 1'b0;
                        if (cur.file_is_open) begin
                           res.file_action = FILE_CLOSE;
                           nxt.file_is_open = 1'b0;
                        end
                        nxt.client_addr = '0;
                     end
                     default: begin
                     end
                  endcase
                  if (nxt.client_addr == 32'd0) begin
                     res.rx_timer_cmd = TIMER_STOP;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.session_active = (nxt.client_addr != 32'd0);
   end

endmodule

### src/tftp_server_session_control_top.sv
// Top level of the single-session TFTP server controller.
//
// Usage: each word on the req_ channel is one event (a parsed packet with
// the file store's answers, a retransmit timer expiry or an idle timer
// expiry). Every accepted event yields exactly one word on the rsp_ channel
// naming the packet to send, the file action and the two timer commands.
// A word is accepted when valid is high and stall is low.
// The csr_ channel writes max_retries (always ready); write it only while
// no event is in flight.
// The input register loads at acceptance; the result register loads from it when
// the event advances, and rsp_valid rises once it holds the word. Throughput: one
// event per cycle while rsp_stall stays low; the session update is a single pass
// of compares and adds between the two registers.
// When the receiver stalls, the result register holds its word, the input
// register takes one more word, and req_stall rises once both are full.
// Reset clears the session (no client), the retry count and the pipeline
// valid bits, and sets max_retries to 10.
module tftp_server_session_control_top import tftpsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_src_ip,
   input  logic [15:0] req_src_port,
   input  logic        req_dest_is_broadcast,
   input  logic [15:0] req_opcode,
   input  logic [15:0] req_block_id,
   input  logic [9:0]  req_payload_len,
   input  logic        req_mode_octet,
   input  logic        req_open_ok,
   input  logic [9:0]  req_read_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_send_kind,
   output logic [31:0] rsp_dest_ip,
   output logic [15:0] rsp_dest_port,
   output logic [15:0] rsp_block_or_code,
   output logic [2:0]  rsp_error_message,
   output logic [9:0]  rsp_data_len,
   output logic [2:0]  rsp_file_action,
   output logic        rsp_open_binary,
   output logic [1:0]  rsp_tx_timer_cmd,
   output logic [1:0]  rsp_rx_timer_cmd,
   output logic        rsp_session_active,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_wdata
);

   item_type    req_item;
   item_type    stage_item;
   logic        stage_valid;
   logic        advance;
   session_type sess_ff;
   session_type sess_in;
   result_type  res_ff;
   result_type  res_in;
   logic        rsp_vld_ff;
   logic        rsp_vld_in;
   logic [3:0]  max_retries_ff;

   assign req_item = '{
      command:           req_command,
      src_ip:            req_src_ip,
      src_port:          req_src_port,
      dest_is_broadcast: req_dest_is_broadcast,
      opcode:            req_opcode,
      block_id:          req_block_id,
      payload_len:       req_payload_len,
      mode_octet:        req_mode_octet,
      open_ok:           req_open_ok,
      read_bytes:        req_read_bytes
   };

   assign advance = stage_valid & (~rsp_vld_ff | ~rsp_stall);
   assign rsp_vld_in = advance | (rsp_vld_ff & rsp_stall);
   assign csr_ready = 1'b1;

   tftpsc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .in_stall  (req_stall),
      .advance   (advance),
      .out_valid (stage_valid),
      .out_item  (stage_item)
   );

   tftpsc_decide u_decide (
      .item        (stage_item),
      .cur         (sess_ff),
      .max_retries (max_retries_ff),
      .nxt         (sess_in),
      .res         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sess_ff <= '0;
         max_retries_ff <= MAX_RETRIES_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (advance) begin
            sess_ff <= sess_in;
         end
         if (csr_valid && csr_ready) begin
            max_retries_ff <= csr_wdata;
         end
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_send_kind = res_ff.send_kind;
   assign rsp_dest_ip = res_ff.dest_ip;
   assign rsp_dest_port = res_ff.dest_port;
   assign rsp_block_or_code = res_ff.block_or_code;
   assign rsp_error_message = res_ff.error_message;
   assign rsp_data_len = res_ff.data_len;
   assign rsp_file_action = res_ff.file_action;
   assign rsp_open_binary = res_ff.open_binary;
   assign rsp_tx_timer_cmd = res_ff.tx_timer_cmd;
   assign rsp_rx_timer_cmd = res_ff.rx_timer_cmd;
   assign rsp_session_active = res_ff.session_active;

endmodule

### tb/tftp_server_session_control_top_test.sv
// Self-checking testbench for the TFTP session controller: event stimulus, session predictor.
`timescale 1ns / 1ps

module tftp_server_session_control_top_test;
   import tftpsc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [31:0] HOST_A = 32'hC0A8_0105;
   localparam logic [31:0] HOST_B = 32'h0A00_0002;
   localparam logic [15:0] PORT_A = 16'd1069;
   localparam logic [15:0] PORT_B = 16'd2001;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [31:0] req_src_ip = '0;
   logic [15:0] req_src_port = '0;
   logic        req_dest_is_broadcast = 1'b0;
   logic [15:0] req_opcode = '0;
   logic [15:0] req_block_id = '0;
   logic [9:0]  req_payload_len = '0;
   logic        req_mode_octet = 1'b0;
   logic        req_open_ok = 1'b0;
   logic [9:0]  req_read_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_send_kind;
   logic [31:0] rsp_dest_ip;
   logic [15:0] rsp_dest_port;
   logic [15:0] rsp_block_or_code;
   logic [2:0]  rsp_error_message;
   logic [9:0]  rsp_data_len;
   logic [2:0]  rsp_file_action;
   logic        rsp_open_binary;
   logic [1:0]  rsp_tx_timer_cmd;
   logic [1:0]  rsp_rx_timer_cmd;
   logic        rsp_session_active;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_wdata = '0;

   item_type    pending_events [$];
   result_type  due_replies [$];
   item_type    current_event = '0;
   session_type sess = '0;
   result_type  pred;
   result_type  reply_seen;
   result_type  reply_due;
   logic [3:0]  retry_limit = MAX_RETRIES_RESET;
   logic [31:0] peer_ip = HOST_A;
   logic [15:0] peer_port = PORT_A;
   bit          busy = 1'b0;
   bit          word_taken = 1'b0;
   bit          reply_taken = 1'b0;
   bit          calm = 1'b0;
   int          req_wait = 0;
   int          rsp_hold = 0;
   int          issued = 0;
   int          errors = 0;

   tftp_server_session_control_top dut (.*);

   always #1 clock = ~clock;

   function automatic int pick_wait();
      if ($urandom_range(40) == 0) calm = !calm;
      if (calm || $urandom_range(2) == 0) return 0;
      return $urandom_range(16);
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   function automatic logic [9:0] rnd10();
      return 10'($urandom);
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic void send_word(input logic [1:0] kind, input logic [31:0] ip,
                                     input logic [15:0] port, input logic [15:0] blk,
                                     input logic [2:0] msg, input logic [9:0] len);
      pred.send_kind = kind;
      pred.dest_ip = ip;
      pred.dest_port = port;
      pred.block_or_code = blk;
      pred.error_message = (kind == KIND_ERROR) ? msg : 3'd0;
      pred.data_len = (kind == KIND_DATA) ? len : 10'd0;
   endfunction

   function automatic void close_session();
      sess.binary_flag = 1'b0;
      if (sess.file_is_open) begin
         pred.file_action = FILE_CLOSE;
         sess.file_is_open = 1'b0;
      end
      sess.client_addr = '0;
   endfunction

   function automatic void session_step(input item_type w);
      logic [9:0]  plen;
      logic [9:0]  rlen;
      logic [16:0] diff;
      bit          no_file;
      plen = (w.payload_len > LEN_LIMIT) ? LEN_LIMIT : w.payload_len;
      rlen = (w.read_bytes > LEN_LIMIT) ? LEN_LIMIT : w.read_bytes;
      no_file = !sess.file_is_open || sess.client_addr == '0;
      pred = '0;
      case (w.command)
         CMD_TX_EXPIRED: begin
            if (sess.retry_count >= retry_limit) begin
               pred.tx_timer_cmd = TIMER_STOP;
               close_session();
               sess.retry_count = '0;
            end else begin
               sess.retry_count = sess.retry_count + 4'd1;
               if (no_file) begin
                  pred.tx_timer_cmd = TIMER_STOP;
               end else begin
                  send_word(KIND_DATA, sess.client_addr, sess.client_port, sess.block_num,
                            3'd0, sess.last_len);
                  pred.tx_timer_cmd = TIMER_RESTART;
               end
            end
         end
         CMD_RX_EXPIRED: begin
            pred.rx_timer_cmd = TIMER_STOP;
            close_session();
         end
         CMD_PACKET: if (!w.dest_is_broadcast) begin
            if (sess.client_addr != '0 && w.src_ip != sess.client_addr) begin
               send_word(KIND_ERROR, w.src_ip, w.src_port, ERR_CODE_BUSY, MSG_BUSY, '0);
            end else begin
               pred.rx_timer_cmd = TIMER_RESTART;
               case (w.opcode)
                  OP_RRQ, OP_WRQ: begin
                     if (sess.client_addr != '0) begin
                        if (w.opcode == OP_RRQ) begin
                           pred.tx_timer_cmd = TIMER_STOP;
                           send_word(KIND_ERROR, w.src_ip, w.src_port, ERR_CODE_ILLEGAL,
                                     MSG_RRQ_UNEXPECTED, '0);
                        end else begin
                           send_word(KIND_ERROR, w.src_ip, w.src_port, ERR_CODE_ILLEGAL,
                                     MSG_WRQ_UNEXPECTED, '0);
                        end
                        close_session();
                     end else begin
                        sess.client_addr = w.src_ip;
                        sess.client_port = w.src_port;
                        sess.binary_flag = w.mode_octet;
                        pred.open_binary = w.mode_octet;
                        if (w.opcode == OP_RRQ) begin
                           pred.file_action = FILE_OPEN_READ;
                           if (!w.open_ok) begin
                              send_word(KIND_ERROR, w.src_ip, w.src_port, ERR_CODE_NOT_FOUND,
                                        MSG_NOT_FOUND, '0);
                              sess.client_addr = '0;
                           end else begin
                              sess.file_is_open = 1'b1;
                              sess.last_len = rlen;
                              sess.final_block = {1'b0, rlen} != BLOCK_LEN;
                              sess.block_num = 16'd1;
                              send_word(KIND_DATA, w.src_ip, w.src_port, 16'd1, 3'd0, rlen);
                              pred.tx_timer_cmd = TIMER_RESTART;
                              sess.retry_count = '0;
                           end
                        end else begin
                           pred.file_action = FILE_OPEN_WRITE;
                           if (!w.open_ok) begin
                              send_word(KIND_ERROR, w.src_ip, w.src_port, ERR_CODE_NOT_FOUND,
                                        MSG_CANNOT_WRITE, '0);
                              sess.client_addr = '0;
                           end else begin
                              sess.file_is_open = 1'b1;
                              sess.block_num = '0;
                              sess.final_block = 1'b0;
                              sess.prev_block = '0;
                              send_word(KIND_ACK, w.src_ip, w.src_port, 16'd0, 3'd0, '0);
                           end
                        end
                     end
                  end
                  OP_DATA: begin
                     diff = {1'b0, w.block_id} - {1'b0, sess.prev_block};
                     sess.block_num = w.block_id;
                     if (sess.prev_block != '0 && sess.prev_block == w.block_id) begin
                        send_word(KIND_ACK, w.src_ip, w.src_port, w.block_id, 3'd0, '0);
                     end else if ($signed(diff) > 17'sd1) begin
                        send_word(KIND_ACK, w.src_ip, w.src_port, sess.prev_block, 3'd0, '0);
                     end else begin
                        sess.prev_block = w.block_id;
                        if (no_file) begin
                           send_word(KIND_ERROR, w.src_ip, w.src_port, ERR_CODE_NOT_OPEN,
                                     MSG_NOT_OPEN, '0);
                        end else begin
                           sess.last_len = plen;
                           if ({1'b0, plen} != BLOCK_LEN) begin
                              pred.file_action = FILE_WRITE_CLOSE;
                              sess.file_is_open = 1'b0;
                              sess.client_addr = '0;
                           end else begin
                              pred.file_action = FILE_WRITE;
                           end
                           send_word(KIND_ACK, w.src_ip, w.src_port, w.block_id, 3'd0, '0);
                        end
                     end
                  end
                  OP_ACK: begin
                     sess.retry_count = '0;
                     if (no_file) begin
                        send_word(KIND_ERROR, w.src_ip, w.src_port, ERR_CODE_NOT_OPEN,
                                  MSG_NOT_OPEN, '0);
                        pred.tx_timer_cmd = TIMER_STOP;
                     end else if (sess.final_block) begin
                        pred.tx_timer_cmd = TIMER_STOP;
                        pred.file_action = FILE_CLOSE;
                        sess.file_is_open = 1'b0;
                        sess.client_addr = '0;
                     end else begin
                        sess.block_num = sess.block_num + 16'd1;
                        pred.file_action = FILE_READ_NEXT;
                        sess.last_len = rlen;
                        sess.final_block = {1'b0, rlen} != BLOCK_LEN;
                        send_word(KIND_DATA, w.src_ip, w.src_port, sess.block_num, 3'd0, rlen);
                        pred.tx_timer_cmd = TIMER_RESTART;
                     end
                  end
                  OP_ERROR: begin
                     pred.tx_timer_cmd = TIMER_STOP;
                     close_session();
                  end
                  default: ;
               endcase
               if (sess.client_addr == '0) pred.rx_timer_cmd = TIMER_STOP;
            end
         end
         default: ;
      endcase
      pred.session_active = sess.client_addr != '0;
   endfunction

   function automatic item_type make_word(input logic [1:0] cmd, input logic [31:0] ip,
                                          input logic [15:0] port, input logic [15:0] op,
                                          input logic [15:0] blk, input logic [9:0] plen,
                                          input logic [9:0] rbytes, input logic octet,
                                          input logic ok);
      item_type w;
      w.command = cmd;
      w.src_ip = ip;
      w.src_port = port;
      w.dest_is_broadcast = 1'b0;
      w.opcode = op;
      w.block_id = blk;
      w.payload_len = plen;
      w.mode_octet = octet;
      w.open_ok = ok;
      w.read_bytes = rbytes;
      return w;
   endfunction

   function automatic item_type noise_word();
      item_type w;
      w.command = 2'($urandom_range(3));
      w.src_ip = $urandom;
      w.src_port = rnd16();
      w.dest_is_broadcast = $urandom_range(3) == 0;
      w.opcode = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      w.block_id = rnd16();
      w.payload_len = rnd10();
      w.mode_octet = coin();
      w.open_ok = coin();
      w.read_bytes = rnd10();
      return w;
   endfunction

   function automatic logic [9:0] block_len();
      return ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'(BLOCK_BYTES);
   endfunction

   function automatic void queue_word(input item_type w);
      pending_events.push_back(w);
      if (w.command != CMD_UNUSED && !(w.command == CMD_PACKET && w.dest_is_broadcast))
         issued++;
   endfunction

   function automatic void new_peer();
      peer_ip = ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom);
      peer_port = rnd16();
   endfunction

   function automatic item_type stranger();
      return make_word(CMD_PACKET, $urandom, rnd16(), 16'($urandom_range(1, 5)), rnd16(),
                       rnd10(), rnd10(), coin(), coin());
   endfunction

   task automatic random_traffic(input int count);
      int          stop_at;
      int          steps;
      logic [15:0] blk;
      stop_at = issued + count;
      while (issued < stop_at) begin
         steps = $urandom_range(1, 14);
         case ($urandom_range(9))
            0, 1: repeat (steps) begin
               queue_word(noise_word());
               if ($urandom_range(1)) begin
                  pending_events[$].src_ip = peer_ip;
               end
            end
            2, 3, 4, 5: begin
               new_peer();
               queue_word(make_word(CMD_PACKET, peer_ip, peer_port, OP_RRQ, rnd16(),
                                    rnd10(), block_len(), coin(),
                                    $urandom_range(7) != 0));
               repeat (steps) case ($urandom_range(9))
                  0: repeat ($urandom_range(1, 17))
                        queue_word(make_word(CMD_TX_EXPIRED, $urandom, rnd16(), rnd16(),
                                             rnd16(), rnd10(), rnd10(), coin(), coin()));
                  1: queue_word(stranger());
                  2: if ($urandom_range(3) == 0)
                        queue_word(make_word(CMD_RX_EXPIRED, $urandom, rnd16(), rnd16(),
                                             rnd16(), rnd10(), rnd10(), 1'b0, 1'b0));
                  default: queue_word(make_word(CMD_PACKET, peer_ip, peer_port, OP_ACK,
                                                rnd16(), rnd10(), block_len(),
                                                coin(), coin()));
               endcase
            end
            default: begin
               new_peer();
               blk = 16'd1;
               queue_word(make_word(CMD_PACKET, peer_ip, peer_port, OP_WRQ, rnd16(),
                                    rnd10(), rnd10(), coin(),
                                    $urandom_range(7) != 0));
               repeat (steps) case ($urandom_range(9))
                  0: queue_word(make_word(CMD_PACKET, peer_ip, peer_port, OP_DATA, blk - 16'd1,
                                          block_len(), rnd10(), 1'b0, 1'b0));
                  1: queue_word(make_word(CMD_PACKET, peer_ip, peer_port, OP_DATA,
                                          blk + 16'($urandom_range(1, 40)), block_len(),
                                          rnd10(), 1'b0, 1'b0));
                  2: queue_word(stranger());
                  3: queue_word(make_word(CMD_TX_EXPIRED, $urandom, rnd16(), rnd16(),
                                          rnd16(), rnd10(), rnd10(), 1'b0, 1'b0));
                  default: begin
                     queue_word(make_word(CMD_PACKET, peer_ip, peer_port, OP_DATA, blk,
                                          block_len(), rnd10(), coin(), coin()));
                     blk = blk + 16'd1;
                  end
               endcase
            end
         endcase
      end
   endtask

   task automatic wait_idle();
      while (pending_events.size() != 0 || busy || due_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
      if (seen !== want) begin
         if (errors < 40)
            $display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
         errors++;
      end
   endtask

   // request side: predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         session_step(current_event);
         due_replies.push_back(pred);
         word_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (word_taken) begin
            word_taken = 1'b0;
            busy = 1'b0;
            req_wait = pick_wait();
         end
         if (!busy) begin
            if (req_wait > 0) begin
               req_wait = req_wait - 1;
            end else if (pending_events.size() != 0) begin
               current_event = pending_events.pop_front();
               busy = 1'b1;
            end
         end
         req_valid <= busy;
         {req_command, req_src_ip, req_src_port, req_dest_is_broadcast, req_opcode,
          req_block_id, req_payload_len, req_mode_octet, req_open_ok,
          req_read_bytes} <= current_event;
      end
   end

   // result side: check against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         reply_seen = {rsp_send_kind, rsp_dest_ip, rsp_dest_port, rsp_block_or_code,
                       rsp_error_message, rsp_data_len, rsp_file_action, rsp_open_binary,
                       rsp_tx_timer_cmd, rsp_rx_timer_cmd, rsp_session_active};
         if (due_replies.size() == 0) begin
            if (errors < 40)
               $display("%0t: unexpected result word %h", $time, reply_seen);
            errors++;
         end else begin
            reply_due = due_replies.pop_front();
            compare_field("send_kind", 32'(reply_due.send_kind),
                          32'(reply_seen.send_kind));
            compare_field("dest_ip", reply_due.dest_ip, reply_seen.dest_ip);
            compare_field("dest_port", 32'(reply_due.dest_port),
                          32'(reply_seen.dest_port));
            compare_field("block_or_code", 32'(reply_due.block_or_code),
                          32'(reply_seen.block_or_code));
            compare_field("error_message", 32'(reply_due.error_message),
                          32'(reply_seen.error_message));
            compare_field("data_len", 32'(reply_due.data_len),
                          32'(reply_seen.data_len));
            compare_field("file_action", 32'(reply_due.file_action),
                          32'(reply_seen.file_action));
            compare_field("open_binary", 32'(reply_due.open_binary),
                          32'(reply_seen.open_binary));
            compare_field("tx_timer_cmd", 32'(reply_due.tx_timer_cmd),
                          32'(reply_seen.tx_timer_cmd));
            compare_field("rx_timer_cmd", 32'(reply_due.rx_timer_cmd),
                          32'(reply_seen.rx_timer_cmd));
            compare_field("session_active", 32'(reply_due.session_active),
                          32'(reply_seen.session_active));
         end
         reply_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reply_taken) begin
         reply_taken = 1'b0;
         rsp_hold = pick_wait();
      end
      if (rsp_hold > 0 && rsp_valid) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : stimulus
      item_type   w;
      logic [3:0] plan [6];
      int         p;
      plan = '{4'd15, 4'd0, 4'd3, 4'd1, 4'd7, 4'd10};
      plan[2] = 4'($urandom);
      plan[4] = 4'($urandom);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_WRQ, 16'd0, 10'd0, 10'd0,
                           1'b1, 1'b1));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_DATA, 16'd1, 10'd512, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_DATA, 16'd1, 10'd512, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_DATA, 16'hFFFF, 10'd512, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_B, PORT_B, OP_RRQ, 16'd0, 10'd0, 10'd0,
                           1'b1, 1'b1));
      w = make_word(CMD_PACKET, HOST_A, PORT_A, OP_DATA, 16'd2, 10'd512, 10'd0, 1'b0, 1'b0);
      w.dest_is_broadcast = 1'b1;
      queue_word(w);
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, 16'hFFFF, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_DATA, 16'd2, 10'd1023, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_DATA, 16'd3, 10'd0, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF, OP_RRQ, 16'hFFFF, 10'd1023,
                           10'd512, 1'b0, 1'b1));
      queue_word(make_word(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF, OP_ACK, 16'd0, 10'd0,
                           10'd1023, 1'b0, 1'b0));
      queue_word(make_word(CMD_TX_EXPIRED, 32'd0, 16'd0, 16'd0, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF, OP_ACK, 16'd7, 10'd0,
                           10'd0, 1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF, OP_ACK, 16'd4, 10'd0,
                           10'd0, 1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_ACK, 16'd1, 10'd0, 10'd512,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_DATA, 16'd0, 10'd512, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_RRQ, 16'd0, 10'd0, 10'd512,
                           1'b1, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_WRQ, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_RRQ, 16'd0, 10'd0, 10'd100,
                           1'b1, 1'b1));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_RRQ, 16'd0, 10'd0, 10'd512,
                           1'b0, 1'b1));
      queue_word(make_word(CMD_PACKET, HOST_B, PORT_B, OP_WRQ, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b1));
      queue_word(make_word(CMD_PACKET, HOST_B, PORT_B, OP_WRQ, 16'd0, 10'd0, 10'd0,
                           1'b1, 1'b1));
      queue_word(make_word(CMD_PACKET, HOST_A, PORT_A, OP_WRQ, 16'd0, 10'd0, 10'd0,
                           1'b1, 1'b1));
      queue_word(make_word(CMD_RX_EXPIRED, 32'd0, 16'd0, 16'd0, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_UNUSED, HOST_A, PORT_A, OP_ACK, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_TX_EXPIRED, 32'd0, 16'd0, 16'd0, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b0));
      queue_word(make_word(CMD_PACKET, 32'd0, PORT_B, OP_RRQ, 16'd0, 10'd0, 10'd512,
                           1'b1, 1'b1));
      queue_word(make_word(CMD_PACKET, 32'd0, PORT_B, OP_ERROR, 16'd0, 10'd0, 10'd0,
                           1'b0, 1'b0));

      for (p = 0; p < 6; p++) begin
         wait_idle();
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_wdata <= plan[p];
         do @(posedge clock); while (!csr_ready);
         retry_limit = plan[p];
         @(negedge clock);
         csr_valid <= 1'b0;
         random_traffic(105);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0 && due_replies.size() == 0) begin
         $display("tftp_server_session_control_top test passed");
      end else begin
         $display("tftp_server_session_control_top test failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("tftp_server_session_control_top test failed");
      $finish;
   end

endmodule
